>>> rtl/core/gfpe_pkg.sv
// Shared types and constants of the GF(2^8) erasure parity encoder.
package gfpe_pkg;

  localparam int ByteW   = 8;
  localparam int IndexW  = 4;
  localparam int CountW  = 5;
  localparam int CfgIdxW = 2;

  // Rows and columns that the four-bit index fields can address.
  localparam int IndexSpan = 16;

  typedef enum logic {
    OpLoad = 1'b0,
    OpData = 1'b1
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFieldPoly   = 2'd0,
    CfgDataCount   = 2'd1,
    CfgParityCount = 2'd2,
    CfgUnused      = 2'd3
  } cfg_index_e;

  typedef struct packed {
    opcode_e             opcode;
    logic [IndexW-1:0]   row_index;
    logic [IndexW-1:0]   col_index;
    logic [ByteW-1:0]    value;
  } in_item_t;

  typedef struct packed {
    logic [IndexW-1:0]   parity_index;
    logic [ByteW-1:0]    parity_byte;
    logic                last;
  } out_item_t;

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic load;    // coefficient write
    logic data;    // data byte in range
    logic first;   // byte of shard 0 restarts the accumulator
    logic emit;    // byte of the last shard captures the results
    logic shift;   // result chain moves one place toward the output
  } cell_ctrl_t;

endpackage

>>> rtl/core/gfpe_cell.sv
// One parity row: coefficient column, GF(2^8) multiply-accumulate and a result slot.
module gfpe_cell #(
  parameter int Lane     = 0,
  parameter int NumCols  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gfpe_pkg::cell_ctrl_t        ctrl_i,
  input  logic                        active_i,
  input  logic [gfpe_pkg::IndexW-1:0] row_i,
  input  logic [gfpe_pkg::IndexW-1:0] col_i,
  input  logic [gfpe_pkg::ByteW-1:0]  value_i,
  input  logic [gfpe_pkg::ByteW-1:0]  poly_i,
  input  logic [gfpe_pkg::ByteW-1:0]  res_next_i,
  output logic [gfpe_pkg::ByteW-1:0]  res_o
);

  localparam int ColAddrW = (NumCols > 1) ? $clog2(NumCols) : 1;

  logic [gfpe_pkg::ByteW-1:0] coef_q [NumCols];
  logic [gfpe_pkg::ByteW-1:0] acc_q, acc_d;
  logic [gfpe_pkg::ByteW-1:0] res_q;
  logic [gfpe_pkg::ByteW-1:0] prod;
  logic                       wr_en;

  // Shift-and-add product, reduced by x^8 + poly after every doubling.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] poly);
    logic [7:0] x;
    logic [7:0] acc;
    x   = a;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc = acc ^ x;
      end
      x = x[7] ? ({x[6:0], 1'b0} ^ poly) : {x[6:0], 1'b0};
    end
    return acc;
  endfunction

  assign wr_en = ctrl_i.load && (row_i == gfpe_pkg::IndexW'(Lane)) &&
                 ({1'b0, col_i} < (gfpe_pkg::IndexW + 1)'(NumCols));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      coef_q[col_i[ColAddrW-1:0]] <= value_i;
    end
  end

  assign prod  = gf_mul(coef_q[col_i[ColAddrW-1:0]], value_i, poly_i);
  assign acc_d = ctrl_i.first ? prod : (acc_q ^ prod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.data && active_i) begin
      acc_q <= acc_d;
    end
  end

  // The column's final byte captures the sum; otherwise results ripple down.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      res_q <= acc_d;
    end else if (ctrl_i.shift) begin
      res_q <= res_next_i;
    end
  end

  assign res_o = res_q;

endmodule

>>> rtl/core/gf256_erasure_parity_encoder.sv
// Top level of the GF(2^8) erasure parity encoder: register file, sequencing, cell chain.
//
// The block computes Reed-Solomon style parity bytes over GF(2^8). Load items
// (opcode 0) write one coefficient per parity row and data shard; data items
// (opcode 1) carry one byte of a column, shard by shard. A row of identical
// cells, one per parity row, multiplies each data byte by the row's
// coefficient and XORs it into the row's accumulator in the same cycle, so
// an item is taken every clock unless it is stalled. The byte of shard 0
// restarts every sum; the byte of shard data_count-1 copies all sums into
// the cells' result slots, which then move one place toward the output per
// delivered item, giving parity_count result items in row order with last
// set on the final one. Rate: one input item per cycle. The item that closes
// a column is held off until the result chain has delivered the previous
// column; the output port moves one result per cycle while out_stall_i is low.
// Bytes whose shard index is not below data_count are dropped, and reading a
// coefficient that was never loaded gives an undefined byte. The configuration
// port always accepts; registers should be written only while the block is idle.
module gf256_erasure_parity_encoder #(
  parameter int MAX_DATA_SHARDS   = 16,
  parameter int MAX_PARITY_SHARDS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input items.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  gfpe_pkg::in_item_t            in_data_i,
  // Result items.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output gfpe_pkg::out_item_t           out_data_o,
  // Configuration writes.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gfpe_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gfpe_pkg::ByteW-1:0]    cfg_data_i
);

  // Only rows and columns below the index span can ever be addressed.
  localparam int NumLanes = (MAX_PARITY_SHARDS < gfpe_pkg::IndexSpan) ?
                            MAX_PARITY_SHARDS : gfpe_pkg::IndexSpan;
  localparam int NumCols  = (MAX_DATA_SHARDS < gfpe_pkg::IndexSpan) ?
                            MAX_DATA_SHARDS : gfpe_pkg::IndexSpan;
  // The data_count register cannot exceed 31, so larger limits never clamp.
  localparam int DataCap  = (MAX_DATA_SHARDS < 31) ? MAX_DATA_SHARDS : 31;

  localparam logic [gfpe_pkg::CountW-1:0] DataLimit   = gfpe_pkg::CountW'(DataCap);
  localparam logic [gfpe_pkg::CountW-1:0] ParityLimit = gfpe_pkg::CountW'(NumLanes);
  localparam logic [gfpe_pkg::CountW-1:0] CountOne    = gfpe_pkg::CountW'(1);

  // Configuration registers.
  logic [gfpe_pkg::ByteW-1:0]  field_poly_q;
  logic [gfpe_pkg::CountW-1:0] data_count_q;
  logic [gfpe_pkg::CountW-1:0] parity_count_q;

  // Output sequencing.
  logic [gfpe_pkg::CountW-1:0] pend_q, pend_d;
  logic [gfpe_pkg::IndexW-1:0] idx_q, idx_d;

  logic [gfpe_pkg::CountW-1:0] data_eff;
  logic [gfpe_pkg::CountW-1:0] parity_eff;
  logic [gfpe_pkg::CountW-1:0] col_ext;
  logic                        is_data;
  logic                        in_range;
  logic                        is_last;
  logic                        chain_free;
  logic                        in_acc;
  logic                        out_acc;
  gfpe_pkg::cell_ctrl_t        ctrl;

  logic [gfpe_pkg::ByteW-1:0]  res [NumLanes];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_poly_q   <= 8'd29;
      data_count_q   <= 5'd4;
      parity_count_q <= 5'd2;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (gfpe_pkg::cfg_index_e'(cfg_index_i))
        gfpe_pkg::CfgFieldPoly:   field_poly_q   <= cfg_data_i;
        gfpe_pkg::CfgDataCount:   data_count_q   <= cfg_data_i[gfpe_pkg::CountW-1:0];
        gfpe_pkg::CfgParityCount: parity_count_q <= cfg_data_i[gfpe_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  // Shard counts are saturated to the range the hardware supports.
  always_comb begin
    if (data_count_q == '0) begin
      data_eff = CountOne;
    end else if (data_count_q > DataLimit) begin
      data_eff = DataLimit;
    end else begin
      data_eff = data_count_q;
    end
    if (parity_count_q == '0) begin
      parity_eff = CountOne;
    end else if (parity_count_q > ParityLimit) begin
      parity_eff = ParityLimit;
    end else begin
      parity_eff = parity_count_q;
    end
  end

  assign col_ext  = {1'b0, in_data_i.col_index};
  assign is_data  = (in_data_i.opcode == gfpe_pkg::OpData);
  assign in_range = (col_ext < data_eff);
  assign is_last  = (col_ext == (data_eff - CountOne));

  assign out_valid_o = (pend_q != '0);
  assign out_acc     = out_valid_o && !out_stall_i;

  // A closing byte may enter once the previous column's results are gone
  // or the last of them leaves in this cycle.
  assign chain_free = (pend_q == '0) || ((pend_q == CountOne) && out_acc);
  assign in_stall_o = is_data && in_range && is_last && !chain_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    ctrl.load  = in_acc && !is_data;
    ctrl.data  = in_acc && is_data && in_range;
    ctrl.first = (in_data_i.col_index == '0);
    ctrl.emit  = ctrl.data && is_last;
    ctrl.shift = out_acc;
  end

  always_comb begin
    pend_d = pend_q;
    idx_d  = idx_q;
    if (ctrl.emit) begin
      pend_d = parity_eff;
      idx_d  = '0;
    end else if (out_acc) begin
      pend_d = pend_q - CountOne;
      idx_d  = idx_q + gfpe_pkg::IndexW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      idx_q  <= '0;
    end else begin
      pend_q <= pend_d;
      idx_q  <= idx_d;
    end
  end

  // One cell per parity row; results ripple toward cell 0, which feeds the port.
  for (genvar r = 0; r < NumLanes; r++) begin : g_cell
    logic [gfpe_pkg::ByteW-1:0] res_next;
    logic                       active;

    if (r + 1 < NumLanes) begin : g_mid
      assign res_next = res[r+1];
    end else begin : g_end
      assign res_next = '0;
    end

    assign active = (gfpe_pkg::CountW'(r) < parity_eff);

    gfpe_cell #(
      .Lane    (r),
      .NumCols (NumCols)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .active_i   (active),
      .row_i      (in_data_i.row_index),
      .col_i      (in_data_i.col_index),
      .value_i    (in_data_i.value),
      .poly_i     (field_poly_q),
      .res_next_i (res_next),
      .res_o      (res[r])
    );
  end

  always_comb begin
    out_data_o.parity_index = idx_q;
    out_data_o.parity_byte  = res[0];
    out_data_o.last         = (pend_q == CountOne);
  end

endmodule

>>> dv/gfpe_parity_checker.sv
// Checker for the GF(2^8) erasure parity encoder: follows every handshake and compares results.
`timescale 1ns / 1ps

module gfpe_parity_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  gfpe_pkg::in_item_t            in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  gfpe_pkg::out_item_t           out_data_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [gfpe_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gfpe_pkg::ByteW-1:0]    cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  localparam int MaxShards = 16;

  logic [gfpe_pkg::ByteW-1:0]  coef_mem [gfpe_pkg::IndexSpan*gfpe_pkg::IndexSpan];
  logic [gfpe_pkg::ByteW-1:0]  row_sum [gfpe_pkg::IndexSpan];
  logic [gfpe_pkg::ByteW-1:0]  poly_q;
  logic [gfpe_pkg::CountW-1:0] data_cnt_q;
  logic [gfpe_pkg::CountW-1:0] parity_cnt_q;
  gfpe_pkg::out_item_t         parity_due [$];

  initial fail_count_o = 0;
  initial pending_o = 0;

  // Shift-and-add product modulo x^8 + poly.
  function automatic logic [gfpe_pkg::ByteW-1:0] gf_product(
      input logic [gfpe_pkg::ByteW-1:0] a,
      input logic [gfpe_pkg::ByteW-1:0] b,
      input logic [gfpe_pkg::ByteW-1:0] poly);
    logic [gfpe_pkg::ByteW:0]   x;
    logic [gfpe_pkg::ByteW-1:0] acc;
    x   = {1'b0, a};
    acc = '0;
    for (int i = 0; i < gfpe_pkg::ByteW; i++) begin
      if (b[i]) acc ^= x[gfpe_pkg::ByteW-1:0];
      x = x << 1;
      if (x[gfpe_pkg::ByteW]) x = x ^ {1'b1, poly};
    end
    return acc;
  endfunction

  function automatic int shard_span(input logic [gfpe_pkg::CountW-1:0] raw);
    if (raw == '0) return 1;
    if (int'(raw) > MaxShards) return MaxShards;
    return int'(raw);
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    gfpe_pkg::out_item_t        got;
    gfpe_pkg::out_item_t        want;
    gfpe_pkg::out_item_t        due;
    int                         d_eff;
    int                         p_eff;
    int                         col;
    logic [gfpe_pkg::ByteW-1:0] prod;
    if (!rst_ni) begin
      for (int i = 0; i < gfpe_pkg::IndexSpan; i++) row_sum[i] = '0;
      poly_q       = 8'd29;
      data_cnt_q   = 5'd4;
      parity_cnt_q = 5'd2;
      parity_due.delete();
      pending_o    = 0;
    end else begin
      // Results first: a result leaving now belongs to items taken earlier.
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (parity_due.size() == 0) begin
          report_mismatch("result with nothing expected", 16'(got), 16'd0);
        end else begin
          want = parity_due.pop_front();
          if (got.parity_index !== want.parity_index)
            report_mismatch("parity_index", 16'(got.parity_index), 16'(want.parity_index));
          if (got.parity_byte !== want.parity_byte)
            report_mismatch("parity_byte", 16'(got.parity_byte), 16'(want.parity_byte));
          if (got.last !== want.last)
            report_mismatch("last", 16'(got.last), 16'(want.last));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (gfpe_pkg::cfg_index_e'(cfg_index_i))
          gfpe_pkg::CfgFieldPoly:   poly_q       = cfg_data_i;
          gfpe_pkg::CfgDataCount:   data_cnt_q   = cfg_data_i[gfpe_pkg::CountW-1:0];
          gfpe_pkg::CfgParityCount: parity_cnt_q = cfg_data_i[gfpe_pkg::CountW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.opcode == gfpe_pkg::OpLoad) begin
          coef_mem[{in_data_i.row_index, in_data_i.col_index}] = in_data_i.value;
        end else begin
          d_eff = shard_span(data_cnt_q);
          p_eff = shard_span(parity_cnt_q);
          col   = int'(in_data_i.col_index);
          if (col < d_eff) begin
            for (int r = 0; r < p_eff; r++) begin
              prod = gf_product(coef_mem[r*gfpe_pkg::IndexSpan + col], in_data_i.value,
                                poly_q);
              row_sum[r] = (col == 0) ? prod : (row_sum[r] ^ prod);
            end
            if (col == d_eff - 1) begin
              for (int r = 0; r < p_eff; r++) begin
                due.parity_index = gfpe_pkg::IndexW'(r);
                due.parity_byte  = row_sum[r];
                due.last         = (r == p_eff - 1);
                parity_due.push_back(due);
              end
            end
          end
        end
      end
      pending_o = parity_due.size();
    end
  end

endmodule

>>> dv/tb_gf256_erasure_parity_encoder.sv
// Testbench top for the GF(2^8) erasure parity encoder: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps

module tb_gf256_erasure_parity_encoder;

  // Cycles without any handshake before the run is declared hung. The slowest
  // correct stretch is a run of random stalls, so this is generous.
  localparam int IdleLimit    = 4000;
  // Cycles allowed after the last expected result before touching registers;
  // a load item leaves nothing to wait for, so give it time to land.
  localparam int SettleCycles = 8;
  localparam int PhaseItems   = 50;
  localparam int PhaseCount   = 9;
  localparam int MaxShards    = 16;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  gfpe_pkg::in_item_t           in_data;
  logic                         out_valid;
  logic                         out_stall;
  gfpe_pkg::out_item_t          out_data;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [gfpe_pkg::CfgIdxW-1:0] cfg_index;
  logic [gfpe_pkg::ByteW-1:0]   cfg_data;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  int send_idle_pct = 14;
  int recv_idle_pct = 59;
  int items_taken = 0;

  // Stimulus-side view of the shard counts and of which table entries hold a
  // coefficient. A data byte that would read an unloaded entry is preceded by
  // loads for exactly those entries.
  int data_span = 4;
  int parity_span = 2;
  bit coef_loaded [gfpe_pkg::IndexSpan*gfpe_pkg::IndexSpan];

  gf256_erasure_parity_encoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  gfpe_parity_checker u_parity_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random on every cycle, independent of the sender,
  // so stalls land on every position of a result burst.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // The watchdog restarts whenever any channel moves an item or a register write.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IdleLimit) begin
      $display("timeout: no handshake for %0d cycles", IdleLimit);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int shard_span(input logic [gfpe_pkg::CountW-1:0] raw);
    if (raw == '0) return 1;
    if (int'(raw) > MaxShards) return MaxShards;
    return int'(raw);
  endfunction

  // Mostly uniform bytes, with the all-zero and all-one extremes weighted up.
  function automatic logic [gfpe_pkg::ByteW-1:0] rand_byte();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return gfpe_pkg::ByteW'($urandom);
  endfunction

  // Offers one item, possibly after a random gap, and returns at the falling
  // edge after it was taken. Valid is left high so back-to-back items never
  // drop it within a time step.
  task automatic send_item(input gfpe_pkg::in_item_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    // Bytes beyond the shard count are ignored by the block and do not count.
    if (!(item.opcode == gfpe_pkg::OpData && int'(item.col_index) >= data_span))
      items_taken++;
  endtask

  task automatic send_load(input int row, input int col,
                           input logic [gfpe_pkg::ByteW-1:0] value);
    gfpe_pkg::in_item_t item;
    item.opcode    = gfpe_pkg::OpLoad;
    item.row_index = gfpe_pkg::IndexW'(row);
    item.col_index = gfpe_pkg::IndexW'(col);
    item.value     = value;
    coef_loaded[row*gfpe_pkg::IndexSpan + col] = 1'b1;
    send_item(item);
  endtask

  task automatic send_data(input int col, input logic [gfpe_pkg::ByteW-1:0] value);
    gfpe_pkg::in_item_t item;
    if (col < data_span) begin
      for (int r = 0; r < parity_span; r++) begin
        if (!coef_loaded[r*gfpe_pkg::IndexSpan + col]) send_load(r, col, rand_byte());
      end
    end
    item.opcode    = gfpe_pkg::OpData;
    item.row_index = gfpe_pkg::IndexW'($urandom);  // not used by data bytes, but exercised
    item.col_index = gfpe_pkg::IndexW'(col);
    item.value     = value;
    send_item(item);
  endtask

  // Stops offering items until every expected result has been delivered, then
  // lets the block settle so that a register write finds it idle.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic cfg_write(input gfpe_pkg::cfg_index_e idx,
                           input logic [gfpe_pkg::ByteW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    case (idx)
      gfpe_pkg::CfgDataCount:   data_span   = shard_span(value[gfpe_pkg::CountW-1:0]);
      gfpe_pkg::CfgParityCount: parity_span = shard_span(value[gfpe_pkg::CountW-1:0]);
      default: ;
    endcase
  endtask

  initial begin
    logic [gfpe_pkg::ByteW-1:0]  poly_set;
    logic [gfpe_pkg::CountW-1:0] data_set;
    logic [gfpe_pkg::CountW-1:0] parity_set;
    int phase_start;
    int pick;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part, at reset settings (four data shards, two parity rows).
    // A zero coefficient, an all-ones coefficient and the far corner of the table.
    send_load(0, 0, 8'hFF);
    send_load(1, 0, 8'h00);
    send_load(15, 15, 8'h80);
    // One column with extreme data bytes, then an all-ones column.
    send_data(0, 8'hFF);
    send_data(1, 8'h00);
    send_data(2, 8'h80);
    send_data(3, 8'h01);
    for (int c = 0; c < 4; c++) send_data(c, 8'hFF);
    // Hold the sender back until both columns have fully come out.
    drain_results();
    // Bytes whose shard index is at or beyond the data count are dropped.
    send_data(15, 8'hAA);
    send_data(4, 8'h55);
    // A skipped shard omits its product.
    send_data(0, 8'h12);
    send_data(2, 8'h34);
    send_data(3, 8'h56);
    // A repeated shard adds its product twice.
    send_data(0, 8'h11);
    send_data(1, 8'h22);
    send_data(1, 8'h22);
    send_data(3, 8'h33);
    // The last shard arriving without a fresh shard 0 emits the running sums.
    send_data(3, 8'h44);
    drain_results();

    for (int ph = 0; ph < PhaseCount; ph++) begin
      // Idling: sender light and receiver heavy, then the reverse, then none.
      if (ph < 3) begin
        send_idle_pct = 14;
        recv_idle_pct = 59;
      end else if (ph < 6) begin
        send_idle_pct = 59;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      case (ph)
        0: begin poly_set = 8'h1D; data_set = 5'd16; parity_set = 5'd16; end
        1: begin poly_set = 8'h00; data_set = 5'd1;  parity_set = 5'd1;  end
        2: begin poly_set = 8'hFF; data_set = 5'd16; parity_set = 5'd1;  end
        3: begin poly_set = 8'h87; data_set = 5'd1;  parity_set = 5'd16; end
        // Out-of-range counts saturate to the legal span.
        5: begin poly_set = 8'h2B; data_set = 5'd0;  parity_set = 5'd31; end
        6: begin
          poly_set   = rand_byte();
          data_set   = gfpe_pkg::CountW'($urandom_range(17, 31));
          parity_set = 5'd0;
        end
        default: begin
          poly_set   = gfpe_pkg::ByteW'($urandom);
          data_set   = gfpe_pkg::CountW'($urandom_range(1, 16));
          parity_set = gfpe_pkg::CountW'($urandom_range(1, 16));
        end
      endcase
      // The upper bits of a count write carry random junk that must be ignored.
      cfg_write(gfpe_pkg::CfgFieldPoly, poly_set);
      cfg_write(gfpe_pkg::CfgDataCount, {3'($urandom), data_set});
      cfg_write(gfpe_pkg::CfgParityCount, {3'($urandom), parity_set});
      if (ph == 5) cfg_write(gfpe_pkg::CfgUnused, gfpe_pkg::ByteW'($urandom));

      phase_start = items_taken;
      while (items_taken - phase_start < PhaseItems) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          // Well-formed column, now and then with a coefficient reload inside it.
          for (int c = 0; c < data_span; c++) begin
            if ($urandom_range(0, 9) == 0)
              send_load($urandom_range(0, 15), $urandom_range(0, 15), rand_byte());
            send_data(c, rand_byte());
          end
        end else if (pick < 75) begin
          send_load($urandom_range(0, 15), $urandom_range(0, 15), rand_byte());
        end else if (pick < 95) begin
          // Broken sequence: shards in any order, some beyond the count.
          repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 1) == 0) send_data($urandom_range(0, 15), rand_byte());
            else send_data($urandom_range(0, data_span - 1), rand_byte());
          end
        end else begin
          drain_results();
        end
      end
      drain_results();
    end

    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
